// ===== rtl/sitoa_pkg.sv =====
// ----------------------------------------------------------------------------
// sitoa_pkg
// Shared types, constants and helpers for the signed integer to ASCII
// converter.
// ----------------------------------------------------------------------------
package sitoa_pkg;

   localparam int VALUE_WIDTH        = 32;
   localparam int CHAR_WIDTH         = 7;
   localparam int RADIX_WIDTH        = 5;
   localparam int DIGIT_WIDTH        = 4;
   localparam int BITS_PER_STEP      = 4;
   localparam int STEPS_PER_DIGIT    = VALUE_WIDTH / BITS_PER_STEP;
   localparam int MAX_DIGITS_DEFAULT = 32;

   localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = 5'd10;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = 5'd16;

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 7'h39;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 7'h2D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ALPHA = 7'h41;
   localparam logic [CHAR_WIDTH-1:0] CHAR_F     = 7'h46;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_EMIT   = 3'b100
   } state_type;

   function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [DIGIT_WIDTH-1:0] d);
      logic [CHAR_WIDTH-1:0] c;
      if (d < 4'd10) begin
         c = CHAR_ZERO + CHAR_WIDTH'(d);
      end else begin
         c = CHAR_ALPHA + CHAR_WIDTH'(d - 4'd10);
      end
      return c;
   endfunction

   function automatic logic [RADIX_WIDTH-1:0] clamp_radix(input logic [RADIX_WIDTH-1:0] r);
      logic [RADIX_WIDTH-1:0] c;
      if (r < RADIX_MIN) begin
         c = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         c = RADIX_MAX;
      end else begin
         c = r;
      end
      return c;
   endfunction

endpackage

// ===== rtl/signed_integer_to_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_integer_to_ascii
// Converts a signed 32-bit integer into its ASCII text in a programmable
// radix, one character per transaction, most significant character first.
// ----------------------------------------------------------------------------
// Each digit is one full pass of the shared long-division unit over the magnitude,
// which retires 4 quotient bits per cycle against the 5-bit radix.
// One value is converted at a time: a new value is accepted only in idle,
// after the last character of the previous value has been loaded. A
// negative value is sent with a leading minus sign.
// Reset is synchronous and active high; the radix returns to 10.
module signed_integer_to_ascii #(
   parameter int MAX_DIGITS = sitoa_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [sitoa_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [sitoa_pkg::CHAR_WIDTH-1:0]     rsp_out_char,
   output logic                                 rsp_last_char,
   input  logic                                 csr_write_en,
   input  logic [sitoa_pkg::RADIX_WIDTH-1:0]    csr_write_data
);
   import sitoa_pkg::*;

   localparam int COUNT_WIDTH = $clog2(MAX_DIGITS + 1);
   localparam int STEP_WIDTH  = $clog2(STEPS_PER_DIGIT);

   state_type                state_ff, state_in;
   logic [RADIX_WIDTH-1:0]   radix_ff, radix_in;
   logic [VALUE_WIDTH-1:0]   mag_ff, mag_in;
   logic [DIGIT_WIDTH-1:0]   rem_ff, rem_in;
   logic [STEP_WIDTH-1:0]    step_ff, step_in;
   logic [COUNT_WIDTH-1:0]   count_ff, count_in;
   logic                     sign_ff, sign_in;
   logic [DIGIT_WIDTH-1:0]   stack_ff [MAX_DIGITS];
   logic [DIGIT_WIDTH-1:0]   stack_in [MAX_DIGITS];
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CHAR_WIDTH-1:0]    rsp_char_ff, rsp_char_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic [DIGIT_WIDTH-1:0]   rem_step;
   logic [BITS_PER_STEP-1:0] qbits;
   logic [RADIX_WIDTH-1:0]   trial;
   logic [VALUE_WIDTH-1:0]   mag_step;
   logic                     digit_done;
   logic                     push;
   logic                     pop;
   logic                     load_slot;

   // Long division of the magnitude by the radix, several quotient bits a cycle.
   always_comb begin
      rem_step = rem_ff;
      qbits    = '0;
      trial    = '0;
      for (int i = 0; i < BITS_PER_STEP; i++) begin
         trial = {rem_step, mag_ff[VALUE_WIDTH-1-i]};
         if (trial >= radix_ff) begin
            qbits[BITS_PER_STEP-1-i] = 1'b1;
            trial = trial - radix_ff;
         end
         rem_step = trial[DIGIT_WIDTH-1:0];
      end
      mag_step   = {mag_ff[VALUE_WIDTH-BITS_PER_STEP-1:0], qbits};
      digit_done = (step_ff == STEP_WIDTH'(STEPS_PER_DIGIT - 1));
   end

   assign load_slot = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign push      = (state_ff == ST_DIVIDE) && digit_done;
   assign pop       = load_slot && !sign_ff;

   always_comb begin
      state_in     = state_ff;
      radix_in     = csr_write_en ? clamp_radix(csr_write_data) : radix_ff;
      mag_in       = mag_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      sign_in      = sign_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      for (int i = 0; i < MAX_DIGITS; i++) begin
         stack_in[i] = stack_ff[i];
      end
      if (push) begin
         stack_in[0] = rem_step;
         for (int i = 1; i < MAX_DIGITS; i++) begin
            stack_in[i] = stack_ff[i-1];
         end
      end else if (pop) begin
         for (int i = 0; i < MAX_DIGITS - 1; i++) begin
            stack_in[i] = stack_ff[i+1];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sign_in  = req_value[VALUE_WIDTH-1];
               mag_in   = req_value[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - req_value) : req_value;
               rem_in   = '0;
               step_in  = '0;
               count_in = '0;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            mag_in  = mag_step;
            rem_in  = rem_step;
            step_in = step_ff + 1'b1;
            if (digit_done) begin
               rem_in   = '0;
               step_in  = '0;
               count_in = count_ff + 1'b1;
               if ((mag_step == '0) || (count_ff == COUNT_WIDTH'(MAX_DIGITS - 1))) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (load_slot) begin
               rsp_valid_in = 1'b1;
               if (sign_ff) begin
                  rsp_char_in = CHAR_MINUS;
                  rsp_last_in = 1'b0;
                  sign_in     = 1'b0;
               end else begin
                  rsp_char_in = digit_char(stack_ff[0]);
                  rsp_last_in = (count_ff == COUNT_WIDTH'(1));
                  count_in    = count_ff - 1'b1;
                  if (count_ff == COUNT_WIDTH'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radix_ff     <= RADIX_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radix_ff     <= radix_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      count_ff    <= count_in;
      sign_ff     <= sign_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         stack_ff[i] <= stack_in[i];
      end
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_char  = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

endmodule

// ===== rtl/sitoa_checker.sv =====
// ----------------------------------------------------------------------------
// sitoa_assertions
// Port-level checks for the signed integer to ASCII converter, bound to
// the top level.
// ----------------------------------------------------------------------------
module sitoa_assertions (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [sitoa_pkg::CHAR_WIDTH-1:0] rsp_out_char,
   input logic                             rsp_last_char
);
   import sitoa_pkg::*;

   // A stalled result transaction keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char) && $stable(rsp_last_char))
      else $error("Result payload changed while stalled.");

   // Every character is a minus sign, a decimal digit or an upper-case hex digit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_char == CHAR_MINUS) ||
                    ((rsp_out_char >= CHAR_ZERO) && (rsp_out_char <= CHAR_NINE)) ||
                    ((rsp_out_char >= CHAR_ALPHA) && (rsp_out_char <= CHAR_F)))
      else $error("Result character outside the digit set.");

   // A minus sign is never the final character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_char == CHAR_MINUS) |-> !rsp_last_char)
      else $error("Minus sign marked as the last character.");

   // After accepting a value the converter is busy in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Input accepted while a conversion was starting.");

   // Accepting a value while no response is pending does not immediately raise one.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("Result appeared before any digit was computed.");

endmodule

bind signed_integer_to_ascii sitoa_assertions u_sitoa_assertions (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_char   (rsp_out_char),
   .rsp_last_char  (rsp_last_char)
);

// ===== bench/sitoa_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sitoa_checker
// Watches the request, response and register ports of the converter. It keeps
// its own copy of the radix, renders every accepted value into the expected
// character string, and compares each response transaction with the oldest
// character still owed.
// ----------------------------------------------------------------------------
module sitoa_checker #(
   parameter int MAX_DIGITS = sitoa_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic [sitoa_pkg::VALUE_WIDTH-1:0]     req_value,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic [sitoa_pkg::CHAR_WIDTH-1:0]      rsp_out_char,
   input  logic                                  rsp_last_char,
   input  logic                                  csr_write_en,
   input  logic [sitoa_pkg::RADIX_WIDTH-1:0]     csr_write_data,
   output int                                    chars_pending,
   output int                                    fail_count
);
   import sitoa_pkg::*;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] ch;
      logic                  last;
   } text_char_type;

   text_char_type          expected_chars[$];
   logic [RADIX_WIDTH-1:0] base_now;

   task automatic render_value(input logic [VALUE_WIDTH-1:0] v,
                               input logic [RADIX_WIDTH-1:0] base);
      logic [VALUE_WIDTH-1:0] mag;
      logic [3:0]             digs[MAX_DIGITS];
      int                     n;
      text_char_type          c;
      mag = v[VALUE_WIDTH-1] ? (~v + 1'b1) : v;
      n   = 0;
      do begin
         digs[n] = 4'(mag % base);
         mag     = mag / base;
         n++;
      end while (mag != 0 && n < MAX_DIGITS);
      if (v[VALUE_WIDTH-1]) begin
         c.ch   = CHAR_MINUS;
         c.last = 1'b0;
         expected_chars.push_back(c);
      end
      for (int i = n - 1; i >= 0; i--) begin
         if (digs[i] < 4'd10) begin
            c.ch = CHAR_ZERO + 7'(digs[i]);
         end else begin
            c.ch = CHAR_ALPHA + 7'(digs[i]) - 7'd10;
         end
         c.last = (i == 0);
         expected_chars.push_back(c);
      end
   endtask

   always @(posedge clock) begin
      text_char_type want;
      if (reset) begin
         expected_chars.delete();
         base_now   = RADIX_RESET;
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               $error("unexpected response: out_char %h last_char %b",
                      rsp_out_char, rsp_last_char);
               fail_count++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_out_char !== want.ch) begin
                  $error("out_char: expected %h, actual %h", want.ch, rsp_out_char);
                  fail_count++;
               end
               if (rsp_last_char !== want.last) begin
                  $error("last_char: expected %b, actual %b", want.last, rsp_last_char);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            render_value(req_value, base_now);
         end
         if (csr_write_en) begin
            if (csr_write_data < RADIX_MIN) begin
               base_now = RADIX_MIN;
            end else if (csr_write_data > RADIX_MAX) begin
               base_now = RADIX_MAX;
            end else begin
               base_now = csr_write_data;
            end
         end
      end
      chars_pending <= expected_chars.size();
   end

endmodule

// ===== bench/tb_signed_integer_to_ascii.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_signed_integer_to_ascii
// Drives the converter with directed corner values in radix 10, 16 and 2,
// then with random values over several radix settings and idle patterns,
// including one long response hold that backs up the request side. The
// checker beside the block predicts and compares every character.
// ----------------------------------------------------------------------------
module tb_signed_integer_to_ascii;
   import sitoa_pkg::*;

   localparam int HOLD_CYCLES = 600;

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_ready;
   logic [VALUE_WIDTH-1:0] req_value      = '0;
   logic                   rsp_valid;
   logic                   rsp_ready      = 1'b0;
   logic [CHAR_WIDTH-1:0]  rsp_out_char;
   logic                   rsp_last_char;
   logic                   csr_write_en   = 1'b0;
   logic [RADIX_WIDTH-1:0] csr_write_data = '0;

   int   chars_pending;
   int   fail_count;
   int   send_idle_pct  = 0;
   int   rsp_stall_pct  = 0;
   logic hold_armed     = 1'b0;
   logic hold_done      = 1'b0;

   signed_integer_to_ascii uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char),
      .csr_write_en  (csr_write_en),
      .csr_write_data(csr_write_data)
   );

   sitoa_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char),
      .csr_write_en  (csr_write_en),
      .csr_write_data(csr_write_data),
      .chars_pending (chars_pending),
      .fail_count    (fail_count)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   initial begin
      #4000000;
      $display("[signed_integer_to_ascii] ERROR");
      $finish;
   end

   initial begin
      int hold_count;
      forever begin
         @(posedge clock);
         if (hold_armed && !hold_done) begin
            rsp_ready <= 1'b0;
            for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) begin
               @(posedge clock);
            end
            hold_done <= 1'b1;
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   function automatic logic [VALUE_WIDTH-1:0] random_value();
      logic [VALUE_WIDTH-1:0] v;
      case ($urandom_range(3))
         0: begin
            v = $urandom;
         end
         1: begin
            v = $urandom_range(300);
            if ($urandom_range(1)) v = ~v + 1'b1;
         end
         2: begin
            v = $urandom >> $urandom_range(31);
            if ($urandom_range(1)) v = ~v + 1'b1;
         end
         default: begin
            if ($urandom_range(1)) begin
               v = 32'h8000_0000 + $urandom_range(4);
            end else begin
               v = 32'h7FFF_FFFF - $urandom_range(4);
            end
         end
      endcase
      return v;
   endfunction

   task automatic send_value(input logic [VALUE_WIDTH-1:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      do begin
         @(posedge clock);
      end while (!req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (chars_pending != 0);
   endtask

   task automatic set_radix(input logic [RADIX_WIDTH-1:0] data);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   task automatic run_phase(input int idle, input int stall,
                            input logic [RADIX_WIDTH-1:0] data, input int count);
      set_radix(data);
      send_idle_pct = idle;
      rsp_stall_pct <= stall;
      repeat (count) send_value(random_value());
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_value(32'd0);
      send_value(32'd1);
      send_value(32'hFFFF_FFFF);
      send_value(32'd9);
      send_value(32'd10);
      send_value(-32'sd10);
      send_value(32'h7FFF_FFFF);
      send_value(32'h8000_0000);
      send_value(32'd1000000000);

      set_radix(5'd31);
      send_value(32'hFFFF_FFFF);
      send_value(32'hFEDC_BA98);
      send_value(32'h7FFF_FFFF);
      send_value(32'h0ABC_DEF0);
      send_value(32'd255);

      set_radix(5'd0);
      send_value(32'h8000_0000);
      send_value(32'h7FFF_FFFF);
      send_value(32'd0);
      send_value(32'd5);
      send_value(-32'sd6);

      run_phase(0, 0, 5'd17, 45);
      run_phase(50, 0, 5'd7, 45);
      run_phase(0, 50, 5'd1, 30);
      run_phase(22, 22, 5'($urandom_range(31)), 45);
      run_phase(22, 22, 5'($urandom_range(31)), 45);

      set_radix(5'd5);
      send_idle_pct = 0;
      rsp_stall_pct <= 0;
      hold_armed    <= 1'b1;
      repeat (40) send_value(random_value());

      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("[signed_integer_to_ascii] OK");
      end else begin
         $display("[signed_integer_to_ascii] ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/sitoa_pkg.sv
rtl/signed_integer_to_ascii.sv
rtl/sitoa_checker.sv
bench/sitoa_checker.sv
bench/tb_signed_integer_to_ascii.sv
